/* sv/fqd_pkg.sv */
`timescale 1ns / 1ps

package fqd_pkg;

    // Default geometry of the queue.
    localparam int unsigned DEPTH_DEF       = 16;
    localparam int unsigned HANDLE_BITS_DEF = 32;

    // Fixed widths of the beat fields.
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned LENGTH_W = 5;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_DEL = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        mode_t                 mode;
        logic [HANDLE_W-1:0]   handle;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [HANDLE_W-1:0]   out_handle;
        logic [LENGTH_W-1:0]   length;
    } rsp_t;

    // Controls broadcast to every storage cell in the row.
    typedef struct packed {
        logic shift;   // every cell takes its right-hand neighbor
        logic load;    // the cell addressed by the tail index takes load_val
    } cell_ctrl_t;

endpackage

/* sv/fqd_cell.sv */
`timescale 1ns / 1ps

module fqd_cell #(
    parameter int unsigned HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF,
    parameter int unsigned IDX_BITS    = 4,
    parameter int unsigned CELL_INDEX  = 0
) (
    input  logic                   clk,
    input  fqd_pkg::cell_ctrl_t    ctrl,
    input  logic [IDX_BITS-1:0]    tail_idx,
    input  logic [HANDLE_BITS-1:0] load_val,
    input  logic [HANDLE_BITS-1:0] shift_in,
    output logic [HANDLE_BITS-1:0] value
);

    logic [HANDLE_BITS-1:0] value_reg;
    logic [HANDLE_BITS-1:0] value_next;
    logic                   load_here;

    // A load into this slot wins over the shift from the neighbor.
    assign load_here = ctrl.load && (tail_idx == IDX_BITS'(CELL_INDEX));

    always_comb
    begin
        priority if (load_here)
        begin
            value_next = load_val;
        end
        else if (ctrl.shift)
        begin
            value_next = shift_in;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* sv/fifo_queue_with_delete.sv */
`timescale 1ns / 1ps

// Ordered queue of nonzero handles held in a row of DEPTH storage cells, with the head in
// cell zero. Each command beat enqueues a handle at the tail, dequeues the head, or deletes
// the first entry equal to a handle while keeping the order of the rest; every command gives
// exactly one response beat with a status, the dequeued handle (zero unless a dequeue
// succeeded) and the length after the operation. For enqueue, dequeue, every error case and
// the unused mode the response is registered at the edge that accepts the command. A delete
// rotates the whole queue once through the head cell, which is the only place a handle is
// compared; the matching entry is dropped instead of being passed back to the tail, and the
// response is registered when the rotation ends. A new command is taken when no delete is in
// progress and the response register is empty or is being read in the same cycle. Stored
// handles are HANDLE_BITS wide; the command handle is cut to that width before the zero
// check. The cells need no clearing after reset: only cells below the length are ever
// read.

module fifo_queue_with_delete #(
    parameter int unsigned DEPTH       = fqd_pkg::DEPTH_DEF,
    parameter int unsigned HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  fqd_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fqd_pkg::rsp_t  rsp
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          left_reg, left_next;
    logic                   found_reg, found_next;
    logic [HANDLE_BITS-1:0] key_reg, key_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    fqd_pkg::rsp_t          rsp_reg, rsp_next;

    fqd_pkg::cell_ctrl_t    ctrl;
    logic [IW-1:0]          tail_idx;
    logic [HANDLE_BITS-1:0] load_val;
    logic [HANDLE_BITS-1:0] cell_val [DEPTH];
    logic [HANDLE_BITS-1:0] head;
    logic [HANDLE_BITS-1:0] cmd_h;
    logic                   cmd_fire;
    logic                   rsp_free;
    logic                   head_match;

    // The command handle, cut to the stored width (zero-extended when that is wider).
    assign cmd_h      = HANDLE_BITS'(cmd.handle);
    assign head       = cell_val[0];
    assign head_match = !found_reg && (head == key_reg);

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE) && rsp_free;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Row of storage cells. Each cell hands its value to its left neighbor on a shift;
    // the last cell has no right neighbor and takes zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [HANDLE_BITS-1:0] right_val;

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid
            assign right_val = cell_val[i+1];
        end

        fqd_cell #(
            .HANDLE_BITS (HANDLE_BITS),
            .IDX_BITS    (IW),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .tail_idx (tail_idx),
            .load_val (load_val),
            .shift_in (right_val),
            .value    (cell_val[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctrl.shift     = 1'b0;
        ctrl.load      = 1'b0;
        tail_idx       = IW'(count_reg);
        load_val       = cmd_h;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = fqd_pkg::ST_OK;
                    rsp_next.out_handle = '0;
                    unique case (cmd.mode)
                        fqd_pkg::MODE_ENQ:
                        begin
                            priority if (cmd_h == '0)
                            begin
                                rsp_next.status = fqd_pkg::ST_ZERO;
                            end
                            else if (count_reg == CW'(DEPTH))
                            begin
                                rsp_next.status = fqd_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.load  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        fqd_pkg::MODE_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = fqd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.shift          = 1'b1;
                                count_next          = count_reg - CW'(1);
                                rsp_next.out_handle = fqd_pkg::HANDLE_W'(head);
                            end
                        end
                        fqd_pkg::MODE_DEL:
                        begin
                            priority if (cmd_h == '0)
                            begin
                                rsp_next.status = fqd_pkg::ST_ZERO;
                            end
                            else if (count_reg == '0)
                            begin
                                rsp_next.status = fqd_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                // The response is posted when the rotation ends.
                                rsp_valid_next = 1'b0;
                                state_next     = S_SCAN;
                                left_next      = count_reg;
                                found_next     = 1'b0;
                                key_next       = cmd_h;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.length = fqd_pkg::LENGTH_W'(count_next);
                end
            end
            S_SCAN:
            begin
                // Rotate the head back to the tail, except for the first match,
                // which is dropped and shortens the queue by one.
                ctrl.shift = 1'b1;
                if (head_match)
                begin
                    found_next = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    ctrl.load = 1'b1;
                    tail_idx  = IW'(count_reg - CW'(1));
                    load_val  = head;
                end
                left_next = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next          = S_IDLE;
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = found_next ? fqd_pkg::ST_OK : fqd_pkg::ST_NOTFOUND;
                    rsp_next.out_handle = '0;
                    rsp_next.length     = fqd_pkg::LENGTH_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The length never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue length exceeds depth");

    // A successful enqueue grows the queue by exactly one entry.
    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.mode == fqd_pkg::MODE_ENQ && cmd_h != '0 && count_reg != CW'(DEPTH))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not grow the queue");

    // A delete rotation never lengthens the queue.
    a_scan_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> count_reg <= $past(count_reg))
        else $error("delete rotation grew the queue");

    // Only a successful dequeue returns a handle, and a held handle is never zero.
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.out_handle != '0) |-> rsp_reg.status == fqd_pkg::ST_OK)
        else $error("handle returned with an error status");

endmodule

/* test/fifo_queue_with_delete_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the handle queue with delete-by-value.
// Every command beat is planned up front and run through the same queue predictor
// twice: once while planning, so that deletes can aim at handles that are really
// held, and once when the block accepts the beat, which yields the response that
// the monitor must see next.
module fifo_queue_with_delete_test;

    localparam int unsigned DEPTH       = fqd_pkg::DEPTH_DEF;
    localparam int unsigned HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF;

    // Command handles are cut to the stored width before anything looks at them.
    localparam logic [fqd_pkg::HANDLE_W-1:0] HANDLE_MASK =
        (HANDLE_BITS >= fqd_pkg::HANDLE_W) ? {fqd_pkg::HANDLE_W{1'b1}} :
        ({fqd_pkg::HANDLE_W{1'b1}} >> (fqd_pkg::HANDLE_W - HANDLE_BITS));

    localparam int unsigned RANDOM_BEATS = 1750;
    localparam int unsigned PHASE_BEATS  = 64;
    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned SETTLE_CYCLES = 24;

    // A planned command beat, with the idle cycles the sender inserts after it
    // and a flag that makes the sender wait for every response before offering it.
    typedef struct packed {
        fqd_pkg::cmd_t c;
        logic [1:0]    gap;
        logic          drain;
    } plan_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_ready;
    fqd_pkg::cmd_t  cmd       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    fqd_pkg::rsp_t  rsp;

    fifo_queue_with_delete #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: one copy of the queue advanced while the stimulus is planned,
    // one advanced as the block accepts beats. The head sits at the lowest slot.
    logic [fqd_pkg::HANDLE_W-1:0] stim_handles  [DEPTH];
    int unsigned                  stim_count  = 0;
    logic [fqd_pkg::HANDLE_W-1:0] check_handles [DEPTH];
    int unsigned                  check_count = 0;

    plan_t          cmd_backlog [$];
    fqd_pkg::rsp_t  awaited_rsps [$];

    int unsigned beats_planned = 0;
    int unsigned cmds_taken    = 0;
    int unsigned rsps_seen     = 0;
    int unsigned errors        = 0;
    int unsigned status_seen [0:4] = '{0, 0, 0, 0, 0};
    int unsigned dequeued      = 0;
    int unsigned deepest       = 0;
    int unsigned holds_done    = 0;

    // Points, in accepted command beats, at which the receiver starts a long hold-off.
    int unsigned hold_at [0:1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};

    // Applies one command to one copy of the queue and returns the response it yields.
    function automatic fqd_pkg::rsp_t apply_queue_op(
        ref logic [fqd_pkg::HANDLE_W-1:0] q [DEPTH],
        ref int unsigned                  cnt,
        input fqd_pkg::cmd_t              c
    );
        fqd_pkg::rsp_t                r;
        logic [fqd_pkg::HANDLE_W-1:0] h;
        int                           pos;
        r.status     = fqd_pkg::ST_OK;
        r.out_handle = '0;
        h   = c.handle & HANDLE_MASK;
        pos = -1;
        case (c.mode)
            fqd_pkg::MODE_ENQ:
            begin
                if (h == '0)
                    r.status = fqd_pkg::ST_ZERO;
                else if (cnt >= DEPTH)
                    r.status = fqd_pkg::ST_FULL;
                else
                begin
                    q[cnt] = h;
                    cnt++;
                end
            end
            fqd_pkg::MODE_DEQ:
            begin
                if (cnt == 0)
                    r.status = fqd_pkg::ST_EMPTY;
                else
                begin
                    r.out_handle = q[0];
                    pos = 0;
                end
            end
            fqd_pkg::MODE_DEL:
            begin
                if (h == '0)
                    r.status = fqd_pkg::ST_ZERO;
                else
                begin
                    for (int i = 0; i < cnt; i++)
                        if (pos < 0 && q[i] == h)
                            pos = i;
                    if (pos < 0)
                        r.status = fqd_pkg::ST_NOTFOUND;
                end
            end
            default:
            begin
            end
        endcase
        // Removal from the head or the middle closes the gap and keeps the order.
        if (pos >= 0)
        begin
            for (int i = pos; i + 1 < cnt; i++)
                q[i] = q[i + 1];
            cnt--;
        end
        r.length = fqd_pkg::LENGTH_W'(cnt);
        return r;
    endfunction

    task automatic plan_beat(fqd_pkg::mode_t m, logic [fqd_pkg::HANDLE_W-1:0] h,
                             logic [1:0] gap, bit drain);
        plan_t p;
        p.c.mode   = m;
        p.c.handle = h;
        p.gap      = gap;
        p.drain    = drain;
        void'(apply_queue_op(stim_handles, stim_count, p.c));
        cmd_backlog.push_back(p);
        beats_planned++;
    endtask

    // Sender: offers the backlog one beat at a time, holding each beat until it is taken.
    // A beat on offer has been taken once the monitor's count catches up with ours.
    int unsigned gap_left  = 0;
    int unsigned sent_gap  = 0;
    int unsigned cmds_sent = 0;

    always @(negedge clk)
    begin
        plan_t nxt;
        if (rst_n && !(cmd_valid && cmds_taken != cmds_sent))
        begin
            if (cmd_valid)
                gap_left = sent_gap;
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0 &&
                     (!cmd_backlog[0].drain || awaited_rsps.size() == 0))
            begin
                nxt = cmd_backlog.pop_front();
                cmds_sent++;
                cmd       <= nxt.c;
                cmd_valid <= 1'b1;
                sent_gap  = nxt.gap;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Receiver: after each response beat it may stall before it is ready again, except in every
    // fourth stretch of 200 accepted command beats, and twice it holds off long enough to back the block up.
    int unsigned stall_left = 0;
    int unsigned long_left  = 0;
    int unsigned hold_slot  = 0;
    int unsigned rsps_noted = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_left > 0)
            begin
                long_left--;
                rsp_ready <= 1'b0;
            end
            else if (hold_slot < 2 && cmds_taken >= hold_at[hold_slot])
            begin
                hold_slot++;
                holds_done++;
                long_left = LONG_HOLD - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (rsps_noted != rsps_seen)
                begin
                    rsps_noted = rsps_seen;
                    stall_left = ((cmds_taken / 200) % 4 == 3) ? 0 : $urandom_range(0, 3);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ready <= 1'b0;
                end
                else
                    rsp_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each response beat against the oldest prediction, then
    // predicts the response of any command beat taken at this edge.
    always @(posedge clk)
    begin
        fqd_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsps_seen++;
                if (rsp.length > deepest)
                    deepest = rsp.length;
                if (awaited_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response beat: status %0d out_handle %h",
                             $realtime, rsp.status, rsp.out_handle);
                    $display("%0t: unexpected response beat: length %0d",
                             $realtime, rsp.length);
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d",
                                 $realtime, want.status, rsp.status);
                    end
                    if (rsp.out_handle !== want.out_handle)
                    begin
                        errors++;
                        $display("%0t: out_handle expected %h, got %h",
                                 $realtime, want.out_handle, rsp.out_handle);
                    end
                    if (rsp.length !== want.length)
                    begin
                        errors++;
                        $display("%0t: length expected %0d, got %0d",
                                 $realtime, want.length, rsp.length);
                    end
                    status_seen[want.status]++;
                    if (want.out_handle != '0)
                        dequeued++;
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                cmds_taken++;
                awaited_rsps.push_back(apply_queue_op(check_handles, check_count, cmd));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run (each beat at most its planned idle
    // gap, a full-queue delete and a receiver stall, plus the long hold-offs).
    initial
    begin
        #2_000_000;
        $display("fifo_queue_with_delete_test: errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned                  phase;
        int unsigned                  n;
        int unsigned                  pick;
        int unsigned                  enq_cut;
        int unsigned                  deq_cut;
        int unsigned                  del_cut;
        int unsigned                  target;
        bit                           quiet;
        bit                           pressure;
        int unsigned                  hold_plan;
        fqd_pkg::mode_t               m;
        logic [fqd_pkg::HANDLE_W-1:0] h;

        // Directed opening: the empty queue, zero handles, the unused mode, the
        // extreme handle values, a repeated handle, misses, and the full queue.
        plan_beat(fqd_pkg::MODE_DEQ, 32'hFFFF_FFFF, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_DEL, 32'h0000_0005, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_ENQ, 32'h0000_0000, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_DEL, 32'h0000_0000, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_NOP, 32'hFFFF_FFFF, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_ENQ, 32'hFFFF_FFFF, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_ENQ, 32'h0000_0001, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_ENQ, 32'h8000_0000, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_ENQ, 32'h0000_0001, 2'($urandom_range(0, 3)), 1'b0);
        // The first of the two equal handles goes, the second stays at the tail.
        plan_beat(fqd_pkg::MODE_DEL, 32'h0000_0001, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_DEL, 32'h0000_0007, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_DEL, 32'h0000_0001, 2'($urandom_range(0, 3)), 1'b0);
        // A dequeue does not care about its handle field, even when it is zero.
        plan_beat(fqd_pkg::MODE_DEQ, 32'h0000_0000, 2'($urandom_range(0, 3)), 1'b0);
        while (stim_count < DEPTH)
            plan_beat(fqd_pkg::MODE_ENQ, $urandom | 32'h0000_0100, 2'd0, 1'b0);
        plan_beat(fqd_pkg::MODE_ENQ, 32'h5A5A_5A5A, 2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_DEL, stim_handles[DEPTH - 1],
                  2'($urandom_range(0, 3)), 1'b0);
        plan_beat(fqd_pkg::MODE_DEL, stim_handles[0], 2'($urandom_range(0, 3)), 1'b0);

        // Random phases, each leaning toward filling, draining or holding the
        // level, so the length keeps sweeping between empty and full.
        target    = beats_planned + RANDOM_BEATS;
        phase     = 0;
        hold_plan = 0;
        while (beats_planned < target)
        begin
            pressure = (phase == 2 || phase == 14);
            quiet    = pressure || ($urandom_range(0, 3) == 0);
            case (pressure ? 0 : $urandom_range(0, 2))
                0:
                begin
                    enq_cut = 65; deq_cut = 75; del_cut = 97;
                end
                1:
                begin
                    enq_cut = 20; deq_cut = 55; del_cut = 97;
                end
                default:
                begin
                    enq_cut = 40; deq_cut = 65; del_cut = 97;
                end
            endcase
            // The sender keeps streaming commands, mostly enqueues, while the receiver holds off.
            if (pressure)
            begin
                hold_at[hold_plan] = beats_planned + 4;
                hold_plan++;
            end
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < enq_cut)
                    m = fqd_pkg::MODE_ENQ;
                else if (pick < deq_cut)
                    m = fqd_pkg::MODE_DEQ;
                else if (pick < del_cut)
                    m = fqd_pkg::MODE_DEL;
                else
                    m = fqd_pkg::MODE_NOP;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    h = '0;
                else if (pick < 28)
                    h = $urandom_range(1, 6);   // a small pool makes repeated handles
                else
                    h = $urandom;
                // Most deletes aim at a handle that is really held, at any position.
                if (m == fqd_pkg::MODE_DEL && stim_count > 0 && $urandom_range(0, 99) < 65)
                    h = stim_handles[$urandom_range(0, stim_count - 1)];
                plan_beat(m, h, quiet ? 2'd0 : 2'($urandom_range(0, 3)),
                          n == 0 && phase % 5 == 4);
            end
            phase++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (cmds_taken != beats_planned || awaited_rsps.size() != 0);
        // A stray response would show up within the longest delete time.
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d command beats: %0d ok, %0d zero handle, %0d full,",
                 cmds_taken, status_seen[fqd_pkg::ST_OK], status_seen[fqd_pkg::ST_ZERO],
                 status_seen[fqd_pkg::ST_FULL]);
        $display("%0d empty, %0d not found; %0d dequeued, deepest %0d, %0d long hold-offs.",
                 status_seen[fqd_pkg::ST_EMPTY], status_seen[fqd_pkg::ST_NOTFOUND],
                 dequeued, deepest, holds_done);
        if (errors == 0)
            $display("fifo_queue_with_delete_test: clean");
        else
            $display("fifo_queue_with_delete_test: errors");
        $finish;
    end

endmodule

/* fifo_queue_with_delete.f */
sv/fqd_pkg.sv
sv/fqd_cell.sv
sv/fifo_queue_with_delete.sv
test/fifo_queue_with_delete_test.sv
